// File: hw/rtl/tndb_pkg.sv
`default_nettype none
package tndb_pkg;

   localparam logic [1:0] FUNC_WR_DIR   = 2'd0;
   localparam logic [1:0] FUNC_WR_COEF  = 2'd1;
   localparam logic [1:0] FUNC_QUERY    = 2'd2;
   localparam logic [1:0] FUNC_RD_BLEND = 2'd3;

   // Q15 weight of one; a query produces at most half of it.
   localparam logic [15:0] WEIGHT_ONE = 16'd32768;

   // Square root operand: squared distance (35 bits) scaled by 2^16.
   localparam int SQ_IN_W = 52;
   localparam int ROOT_W  = SQ_IN_W / 2;

   typedef struct packed {
      logic              done;
      logic [ROOT_W-1:0] root;
   } sqrt_stat_type;

   // Weighted mix of a (nearest) and b (second) with weight w on b,
   // rounded to nearest with halves rounded up.
   function automatic logic signed [19:0] blend16(input logic signed [15:0] a,
                                                  input logic signed [15:0] b,
                                                  input logic [15:0] w);
      logic signed [17:0] wb;
      logic signed [17:0] wa;
      logic signed [35:0] acc;
      wb  = $signed({2'b00, w});
      wa  = 18'sd32768 - wb;
      acc = 36'(a * wa) + 36'(b * wb) + 36'sd16384;
      return acc[34:15];
   endfunction

endpackage
`default_nettype wire

// File: hw/rtl/tndb_isqrt.sv
`default_nettype none
module tndb_isqrt (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [tndb_pkg::SQ_IN_W-1:0] operand,
   output tndb_pkg::sqrt_stat_type           stat
);
   import tndb_pkg::*;

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [SQ_IN_W-1:0] v_ff, v_in;
   logic [SQ_IN_W-1:0] r_ff, r_in;
   logic [SQ_IN_W-1:0] bit_ff, bit_in;
   logic [SQ_IN_W-1:0] trial;

   // One result bit per cycle; done pulses once the last bit is formed.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      v_in    = v_ff;
      r_in    = r_ff;
      bit_in  = bit_ff;
      trial   = r_ff + bit_ff;
      if (start && !busy_ff) begin
         busy_in = 1'b1;
         v_in    = operand;
         r_in    = '0;
         bit_in  = SQ_IN_W'(1) << (SQ_IN_W - 2);
      end else if (busy_ff) begin
         if (v_ff >= trial) begin
            v_in = v_ff - trial;
            r_in = (r_ff >> 1) + bit_ff;
         end else begin
            r_in = r_ff >> 1;
         end
         bit_in = bit_ff >> 2;
         if (bit_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      v_ff   <= v_in;
      r_ff   <= r_in;
      bit_ff <= bit_in;
   end

   assign stat.done = done_ff;
   assign stat.root = r_ff[ROOT_W-1:0];

endmodule
`default_nettype wire

// File: hw/rtl/two_nearest_direction_blend_unit.sv
// Direction table with two-nearest blending. Writes of a direction or a coefficient and reads
// outside the coefficient range are answered as soon as they are accepted. A blended
// coefficient read takes two reads of the coefficient memories (one port each), one blend
// and the handoff of the result. A query scans the first measurement_count entries, at most
// MEAS_ENTRIES, through the single read port of the direction memory, one entry per cycle
// through the read register and the squared-distance register. When a second entry was
// found it then runs two bit-serial square roots and a bit-serial division (skipped for a
// zero distance sum); last it reads the two chosen directions. One item is in flight at a
// time; the next item is taken once the result has been delivered.
`default_nettype none
module two_nearest_direction_blend_unit #(
   parameter int MEAS_ENTRIES = 64,
   parameter int COEF_COUNT   = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               csr_write_enable,
   input  wire logic [6:0]         csr_write_data,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [1:0]         req_func,
   input  wire logic [5:0]         req_meas_index,
   input  wire logic [9:0]         req_coef_index,
   input  wire logic               req_channel,
   input  wire logic signed [15:0] req_coef_real,
   input  wire logic signed [15:0] req_coef_imag,
   input  wire logic signed [15:0] req_azimuth,
   input  wire logic signed [13:0] req_elevation,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [5:0]              rsp_nearest_index,
   output logic [5:0]              rsp_second_index,
   output logic [15:0]             rsp_blend_weight,
   output logic signed [15:0]      rsp_blended_azimuth,
   output logic signed [13:0]      rsp_blended_elevation,
   output logic signed [15:0]      rsp_left_real,
   output logic signed [15:0]      rsp_left_imag,
   output logic signed [15:0]      rsp_right_real,
   output logic signed [15:0]      rsp_right_imag
);
   import tndb_pkg::*;

   localparam int IW    = $clog2(MEAS_ENTRIES);
   localparam int CNT_W = $clog2(MEAS_ENTRIES + 1);
   localparam int CI_W  = (COEF_COUNT > 1) ? $clog2(COEF_COUNT) : 1;
   localparam int DEPTH = MEAS_ENTRIES * COEF_COUNT;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_SCAN   = 4'd1;
   localparam logic [3:0] S_SQRT1  = 4'd2;
   localparam logic [3:0] S_SQRT2  = 4'd3;
   localparam logic [3:0] S_DIV    = 4'd4;
   localparam logic [3:0] S_DIR_A  = 4'd5;
   localparam logic [3:0] S_DIR_B  = 4'd6;
   localparam logic [3:0] S_DIR_C  = 4'd7;
   localparam logic [3:0] S_COEF_A = 4'd8;
   localparam logic [3:0] S_COEF_B = 4'd9;
   localparam logic [3:0] S_COEF_C = 4'd10;

   function automatic logic [AW-1:0] coef_addr(input logic [IW-1:0] m,
                                               input logic [CI_W-1:0] c);
      return AW'(m) * AW'(COEF_COUNT) + AW'(c);
   endfunction

   // Memories: direction {elevation, azimuth}, coefficient {imag, real}.
   logic [29:0] dir_mem  [MEAS_ENTRIES];
   logic [31:0] left_mem [DEPTH];
   logic [31:0] right_mem[DEPTH];
   logic [29:0] dir_rdata_ff;
   logic [31:0] left_rdata_ff, right_rdata_ff;
   logic [IW-1:0] dir_raddr;
   logic [AW-1:0] coef_raddr, coef_waddr;
   logic dir_we, left_we, right_we;

   // Control.
   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [6:0] count_ff, count_in;

   // Committed query results.
   logic [IW-1:0]      nearest_ff, nearest_in;
   logic [IW-1:0]      second_ff, second_in;
   logic [15:0]        weight_ff, weight_in;
   logic signed [15:0] baz_ff, baz_in;
   logic signed [13:0] bel_ff, bel_in;
   logic signed [15:0] lr_ff, lr_in, li_ff, li_in, rr_ff, rr_in, ri_ff, ri_in;

   // Working registers.
   logic signed [15:0] tgt_az_ff, tgt_az_in;
   logic signed [13:0] tgt_el_ff, tgt_el_in;
   logic [CNT_W-1:0]   scan_n_ff, scan_n_in, scan_addr_ff, scan_addr_in;
   logic               rd_valid_ff, rd_valid_in, sq_valid_ff, sq_valid_in;
   logic [IW-1:0]      rd_idx_ff, rd_idx_in, sq_idx_ff, sq_idx_in;
   logic [34:0]        sq_ff, sq_in, b1_ff, b1_in, b2_ff, b2_in;
   logic               have1_ff, have1_in, have2_ff, have2_in;
   logic [IW-1:0]      i1_ff, i1_in, i2_ff, i2_in;
   logic [ROOT_W-1:0]  d1_ff, d1_in;
   logic [ROOT_W:0]    sum_ff, sum_in;
   logic [15:0]        num_lo_ff, num_lo_in;
   logic [ROOT_W:0]    rem_ff, rem_in;
   logic [3:0]         div_cnt_ff, div_cnt_in;
   logic [15:0]        q_ff, q_in, w_ff, w_in;
   logic [CI_W-1:0]    ci_ff, ci_in;
   logic [29:0]        x1_ff, x1_in;
   logic [31:0]        l1_ff, l1_in, r1_ff, r1_in;

   logic sqrt_start;
   logic [SQ_IN_W-1:0] sqrt_operand;
   sqrt_stat_type sqrt_stat;

   logic req_fire, meas_ok, ci_ok;
   logic [CNT_W-1:0] req_n;
   logic signed [16:0] da;
   logic signed [14:0] de;
   logic [34:0] sq_calc;
   logic [ROOT_W:0] sum_calc;
   logic [41:0] num_calc;
   logic [ROOT_W+1:0] div_trial;

   tndb_isqrt u_isqrt (
      .clock   (clock),
      .reset   (reset),
      .start   (sqrt_start),
      .operand (sqrt_operand),
      .stat    (sqrt_stat)
   );

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign req_fire  = req_valid && req_ready;
   assign meas_ok   = {26'd0, req_meas_index} < 32'(MEAS_ENTRIES);
   assign ci_ok     = {22'd0, req_coef_index} < 32'(COEF_COUNT);
   assign req_n     = ({25'd0, count_ff} > 32'(MEAS_ENTRIES)) ? CNT_W'(MEAS_ENTRIES)
                                                              : CNT_W'(count_ff);
   assign coef_waddr = coef_addr(IW'(req_meas_index), CI_W'(req_coef_index));

   // Squared distance of the entry read last cycle to the target.
   assign da      = 17'(signed'(dir_rdata_ff[15:0])) - 17'(tgt_az_ff);
   assign de      = 15'(signed'(dir_rdata_ff[29:16])) - 15'(tgt_el_ff);
   assign sq_calc = 35'(unsigned'(34'(da * da))) + 35'(unsigned'(30'(de * de)));

   assign sum_calc  = {1'b0, d1_ff} + {1'b0, sqrt_stat.root};
   assign num_calc  = {d1_ff, 15'd0} + 42'(sum_calc >> 1);
   assign div_trial = {rem_ff, num_lo_ff[div_cnt_ff]};

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      count_in     = csr_write_enable ? csr_write_data : count_ff;
      nearest_in   = nearest_ff;
      second_in    = second_ff;
      weight_in    = weight_ff;
      baz_in       = baz_ff;
      bel_in       = bel_ff;
      lr_in        = lr_ff;
      li_in        = li_ff;
      rr_in        = rr_ff;
      ri_in        = ri_ff;
      tgt_az_in    = tgt_az_ff;
      tgt_el_in    = tgt_el_ff;
      scan_n_in    = scan_n_ff;
      scan_addr_in = scan_addr_ff;
      rd_valid_in  = 1'b0;
      rd_idx_in    = rd_idx_ff;
      sq_valid_in  = rd_valid_ff;
      sq_in        = sq_calc;
      sq_idx_in    = rd_idx_ff;
      b1_in        = b1_ff;
      b2_in        = b2_ff;
      have1_in     = have1_ff;
      have2_in     = have2_ff;
      i1_in        = i1_ff;
      i2_in        = i2_ff;
      d1_in        = d1_ff;
      sum_in       = sum_ff;
      num_lo_in    = num_lo_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      q_in         = q_ff;
      w_in         = w_ff;
      ci_in        = ci_ff;
      x1_in        = x1_ff;
      l1_in        = l1_ff;
      r1_in        = r1_ff;
      dir_we       = 1'b0;
      left_we      = 1'b0;
      right_we     = 1'b0;
      dir_raddr    = i1_ff;
      coef_raddr   = coef_addr(nearest_ff, ci_ff);
      sqrt_start   = 1'b0;
      sqrt_operand = {1'b0, b1_ff, 16'd0};

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               lr_in = '0;
               li_in = '0;
               rr_in = '0;
               ri_in = '0;
               case (req_func)
                  FUNC_WR_DIR: begin
                     dir_we       = meas_ok;
                     rsp_valid_in = 1'b1;
                  end
                  FUNC_WR_COEF: begin
                     left_we      = meas_ok && ci_ok && !req_channel;
                     right_we     = meas_ok && ci_ok && req_channel;
                     rsp_valid_in = 1'b1;
                  end
                  FUNC_QUERY: begin
                     tgt_az_in    = req_azimuth;
                     tgt_el_in    = req_elevation;
                     scan_n_in    = req_n;
                     scan_addr_in = '0;
                     have1_in     = 1'b0;
                     have2_in     = 1'b0;
                     i1_in        = '0;
                     i2_in        = '0;
                     w_in         = '0;
                     state_in     = S_SCAN;
                  end
                  default: begin
                     if (ci_ok) begin
                        ci_in    = CI_W'(req_coef_index);
                        state_in = S_COEF_A;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (scan_addr_ff < scan_n_ff) begin
               dir_raddr    = IW'(scan_addr_ff);
               rd_valid_in  = 1'b1;
               rd_idx_in    = IW'(scan_addr_ff);
               scan_addr_in = scan_addr_ff + 1'b1;
            end
            if (sq_valid_ff) begin
               // Strict less-than keeps the lower index on a tie.
               if (!have1_ff || sq_ff < b1_ff) begin
                  if (have1_ff) begin
                     b2_in    = b1_ff;
                     i2_in    = i1_ff;
                     have2_in = 1'b1;
                  end
                  b1_in    = sq_ff;
                  i1_in    = sq_idx_ff;
                  have1_in = 1'b1;
               end else if (!have2_ff || sq_ff < b2_ff) begin
                  b2_in    = sq_ff;
                  i2_in    = sq_idx_ff;
                  have2_in = 1'b1;
               end
            end else if (!rd_valid_ff && scan_addr_ff == scan_n_ff) begin
               if (!have2_ff) begin
                  i2_in    = i1_ff;
                  state_in = S_DIR_A;
               end else begin
                  sqrt_start = 1'b1;
                  state_in   = S_SQRT1;
               end
            end
         end
         S_SQRT1: begin
            if (sqrt_stat.done) begin
               d1_in        = sqrt_stat.root;
               sqrt_start   = 1'b1;
               sqrt_operand = {1'b0, b2_ff, 16'd0};
               state_in     = S_SQRT2;
            end
         end
         S_SQRT2: begin
            if (sqrt_stat.done) begin
               if (sum_calc == '0) begin
                  w_in     = '0;
                  state_in = S_DIR_A;
               end else begin
                  // The quotient fits 16 bits, so the top of the numerator
                  // is already below the divisor.
                  sum_in     = sum_calc;
                  num_lo_in  = num_calc[15:0];
                  rem_in     = (ROOT_W+1)'(num_calc >> 16);
                  div_cnt_in = 4'd15;
                  state_in   = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (div_trial >= {1'b0, sum_ff}) begin
               rem_in = (ROOT_W+1)'(div_trial - {1'b0, sum_ff});
               q_in   = {q_ff[14:0], 1'b1};
            end else begin
               rem_in = (ROOT_W+1)'(div_trial);
               q_in   = {q_ff[14:0], 1'b0};
            end
            if (div_cnt_ff == 4'd0) begin
               w_in     = q_in;
               state_in = S_DIR_A;
            end else begin
               div_cnt_in = div_cnt_ff - 4'd1;
            end
         end
         S_DIR_A: begin
            dir_raddr = i1_ff;
            state_in  = S_DIR_B;
         end
         S_DIR_B: begin
            dir_raddr = i2_ff;
            x1_in     = dir_rdata_ff;
            state_in  = S_DIR_C;
         end
         S_DIR_C: begin
            baz_in = 16'(blend16(signed'(x1_ff[15:0]), signed'(dir_rdata_ff[15:0]), w_ff));
            bel_in = 14'(blend16(16'(signed'(x1_ff[29:16])),
                                 16'(signed'(dir_rdata_ff[29:16])), w_ff));
            nearest_in   = i1_ff;
            second_in    = i2_ff;
            weight_in    = w_ff;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_COEF_A: begin
            coef_raddr = coef_addr(nearest_ff, ci_ff);
            state_in   = S_COEF_B;
         end
         S_COEF_B: begin
            coef_raddr = coef_addr(second_ff, ci_ff);
            l1_in      = left_rdata_ff;
            r1_in      = right_rdata_ff;
            state_in   = S_COEF_C;
         end
         S_COEF_C: begin
            lr_in = 16'(blend16(signed'(l1_ff[15:0]), signed'(left_rdata_ff[15:0]),
                                weight_ff));
            li_in = 16'(blend16(signed'(l1_ff[31:16]), signed'(left_rdata_ff[31:16]),
                                weight_ff));
            rr_in = 16'(blend16(signed'(r1_ff[15:0]), signed'(right_rdata_ff[15:0]),
                                weight_ff));
            ri_in = 16'(blend16(signed'(r1_ff[31:16]), signed'(right_rdata_ff[31:16]),
                                weight_ff));
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= 7'd1;
         nearest_ff   <= '0;
         second_ff    <= '0;
         weight_ff    <= '0;
         baz_ff       <= '0;
         bel_ff       <= '0;
         lr_ff        <= '0;
         li_ff        <= '0;
         rr_ff        <= '0;
         ri_ff        <= '0;
         rd_valid_ff  <= 1'b0;
         sq_valid_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         nearest_ff   <= nearest_in;
         second_ff    <= second_in;
         weight_ff    <= weight_in;
         baz_ff       <= baz_in;
         bel_ff       <= bel_in;
         lr_ff        <= lr_in;
         li_ff        <= li_in;
         rr_ff        <= rr_in;
         ri_ff        <= ri_in;
         rd_valid_ff  <= rd_valid_in;
         sq_valid_ff  <= sq_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tgt_az_ff    <= tgt_az_in;
      tgt_el_ff    <= tgt_el_in;
      scan_n_ff    <= scan_n_in;
      scan_addr_ff <= scan_addr_in;
      rd_idx_ff    <= rd_idx_in;
      sq_ff        <= sq_in;
      sq_idx_ff    <= sq_idx_in;
      b1_ff        <= b1_in;
      b2_ff        <= b2_in;
      have1_ff     <= have1_in;
      have2_ff     <= have2_in;
      i1_ff        <= i1_in;
      i2_ff        <= i2_in;
      d1_ff        <= d1_in;
      sum_ff       <= sum_in;
      num_lo_ff    <= num_lo_in;
      rem_ff       <= rem_in;
      div_cnt_ff   <= div_cnt_in;
      q_ff         <= q_in;
      w_ff         <= w_in;
      ci_ff        <= ci_in;
      x1_ff        <= x1_in;
      l1_ff        <= l1_in;
      r1_ff        <= r1_in;
   end

   always_ff @(posedge clock) begin
      if (dir_we) begin
         dir_mem[IW'(req_meas_index)] <= {req_elevation, req_azimuth};
      end
      dir_rdata_ff <= dir_mem[dir_raddr];
   end

   always_ff @(posedge clock) begin
      if (left_we) begin
         left_mem[coef_waddr] <= {req_coef_imag, req_coef_real};
      end
      left_rdata_ff <= left_mem[coef_raddr];
   end

   always_ff @(posedge clock) begin
      if (right_we) begin
         right_mem[coef_waddr] <= {req_coef_imag, req_coef_real};
      end
      right_rdata_ff <= right_mem[coef_raddr];
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_nearest_index     = 6'(nearest_ff);
   assign rsp_second_index      = 6'(second_ff);
   assign rsp_blend_weight      = weight_ff;
   assign rsp_blended_azimuth   = baz_ff;
   assign rsp_blended_elevation = bel_ff;
   assign rsp_left_real         = lr_ff;
   assign rsp_left_imag         = li_ff;
   assign rsp_right_real        = rr_ff;
   assign rsp_right_imag        = ri_ff;

endmodule
`default_nettype wire

// File: hw/rtl/tndb_checker.sv
`default_nettype none
module tndb_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [5:0]  rsp_nearest_index,
   input wire logic [15:0] rsp_blend_weight
);
   import tndb_pkg::*;

   // A waiting result holds until it is taken.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_blend_weight)
                                  && $stable(rsp_nearest_index))
      else $error("result changed while stalled");

   // Only one item is in flight, so no new item is taken while a result waits.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while a result is pending");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input ready right after an accepted item");

   a_weight_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_blend_weight <= WEIGHT_ONE)
      else $error("blend weight above one");

endmodule

bind two_nearest_direction_blend_unit tndb_checker u_tndb_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_nearest_index (rsp_nearest_index),
   .rsp_blend_weight  (rsp_blend_weight)
);
`default_nettype wire
